// ===== hdl/rcast_pkg.sv =====
// shared types and constants of the column ray caster
package rcast_pkg;

	localparam int NUM_W = 26;
	localparam int DEN_W = 17;
	localparam int CNT_W = 5;

	localparam logic [23:0] DELTA_SAT = 24'hFFFFFF;
	localparam logic [7:0] DOOR_KIND = 8'd5;
	localparam logic [15:0] DOOR_DIST = 16'd128;
	localparam logic [15:0] CAMX_BIAS = 16'd16384;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CAST = 1'b1;

	localparam logic [2:0] REG_POS_X = 3'd0;
	localparam logic [2:0] REG_POS_Y = 3'd1;
	localparam logic [2:0] REG_DIR_X = 3'd2;
	localparam logic [2:0] REG_DIR_Y = 3'd3;
	localparam logic [2:0] REG_PLANE_X = 3'd4;
	localparam logic [2:0] REG_PLANE_Y = 3'd5;

	typedef struct packed {
		logic start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic [9:0] column_out;
		logic hit;
		logic [7:0] wall_kind;
		logic side_y;
		logic [15:0] distance;
		logic signed [15:0] wall_start;
		logic signed [15:0] wall_end;
		logic [5:0] tex_x;
		logic door_found;
	} result_t;

endpackage

// ===== hdl/rcast_if.sv =====
// valid/ready channels for cast requests and cast results
interface rcast_in_if;
	logic valid;
	logic ready;
	logic op;
	logic [9:0] column;
	logic [5:0] cell_x;
	logic [5:0] cell_y;
	logic [7:0] cell_value;

	modport source(output valid, op, column, cell_x, cell_y, cell_value, input ready);
	modport sink(input valid, op, column, cell_x, cell_y, cell_value, output ready);
endinterface

interface rcast_out_if;
	logic valid;
	logic ready;
	logic [9:0] column_out;
	logic hit;
	logic [7:0] wall_kind;
	logic side_y;
	logic [15:0] distance;
	logic signed [15:0] wall_start;
	logic signed [15:0] wall_end;
	logic [5:0] tex_x;
	logic door_found;

	modport source(output valid, column_out, hit, wall_kind, side_y, distance, wall_start,
		wall_end, tex_x, door_found, input ready);
	modport sink(input valid, column_out, hit, wall_kind, side_y, distance, wall_start,
		wall_end, tex_x, door_found, output ready);
endinterface

// ===== hdl/rcast_map.sv =====
// map cell memory with a clearing pass after reset
module rcast_map #(
	parameter int AW = 12,
	parameter int DEPTH = 4096
) (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [AW-1:0] wr_addr,
	input logic [7:0] wr_data,
	input logic [AW-1:0] rd_addr,
	output logic [7:0] rd_data,
	output logic busy
);

	logic [7:0] mem [DEPTH];
	logic [AW:0] clr_q;
	logic clearing_q;

	assign busy = clearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == (AW+1)'(DEPTH - 1))
				clearing_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q)
			mem[clr_q[AW-1:0]] <= 8'd0;
		else if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== hdl/rcast_div.sv =====
// restoring divider, one quotient bit per cycle
module rcast_div (
	input logic clk,
	input logic arst_n,
	input rcast_pkg::div_req_t req,
	output logic [rcast_pkg::NUM_W-1:0] quo,
	output logic done
);

	logic [rcast_pkg::NUM_W-1:0] num_q;
	logic [rcast_pkg::DEN_W-1:0] den_q;
	logic [rcast_pkg::DEN_W-1:0] rem_q;
	logic [rcast_pkg::CNT_W-1:0] cnt_q;
	logic done_q;
	logic [rcast_pkg::DEN_W:0] trial;

	assign trial = {rem_q, num_q[rcast_pkg::NUM_W-1]};
	assign quo = num_q;
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start)
				cnt_q <= rcast_pkg::CNT_W'(rcast_pkg::NUM_W);
			else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == rcast_pkg::CNT_W'(1))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= rcast_pkg::DEN_W'(trial - {1'b0, den_q});
				num_q <= {num_q[rcast_pkg::NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[rcast_pkg::DEN_W-1:0];
				num_q <= {num_q[rcast_pkg::NUM_W-2:0], 1'b0};
			end
		end
	end

endmodule

// ===== hdl/dda_wall_column_cast.sv =====
// Grid ray caster: op 0 writes one map cell and gives no result; op 1 casts one screen column
// and gives one result (a column at or beyond NUM_COLS gives none). After reset the map memory
// is cleared one cell per cycle before the first item is taken. A cast that has finished waits
// in S_DONE until the output register is free. Camera x comes from a reciprocal multiply. The
// shared bit-serial divider gives both deltas, and the wall height on a hit. Each DDA step
// reads the map, then tests the cell. A write goes to the map as it is accepted. The result
// register lets the next item start while a result waits.
module dda_wall_column_cast #(
	parameter int NUM_COLS = 1024,
	parameter int NUM_ROWS = 768,
	parameter int MAP_DIM = 64,
	parameter int MAX_STEPS = 60,
	parameter int TEXTURE_SIZE = 64
) (
	input logic clk,
	input logic arst_n,
	rcast_in_if.sink req,
	rcast_out_if.source rsp,
	input logic wr_en,
	input logic [2:0] wr_index,
	input logic [15:0] wr_data
);

	localparam int AW = $clog2(MAP_DIM * MAP_DIM);
	localparam int CW = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;
	// ceil(2^37 / NUM_COLS); (col * recip) >> 22 equals (col << 15) / NUM_COLS for col < NUM_COLS
	localparam logic [33:0] CAMX_RECIP =
		34'(((64'd1 << 37) + 64'(NUM_COLS) - 64'd1) / 64'(NUM_COLS));

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CAM = 4'd1;
	localparam logic [3:0] S_RDX = 4'd2;
	localparam logic [3:0] S_RDY = 4'd3;
	localparam logic [3:0] S_DX = 4'd4;
	localparam logic [3:0] S_DY = 4'd5;
	localparam logic [3:0] S_SDX = 4'd6;
	localparam logic [3:0] S_SDY = 4'd7;
	localparam logic [3:0] S_STEP = 4'd8;
	localparam logic [3:0] S_CHK = 4'd9;
	localparam logic [3:0] S_DIST = 4'd10;
	localparam logic [3:0] S_HDIV = 4'd11;
	localparam logic [3:0] S_WALL = 4'd12;
	localparam logic [3:0] S_FIN = 4'd13;
	localparam logic [3:0] S_DONE = 4'd14;

	logic [15:0] pos_x_q, pos_y_q, dir_x_q, dir_y_q, plane_x_q, plane_y_q;
	logic [3:0] state_q;
	logic [9:0] col_q;
	logic signed [15:0] camx_q;
	logic signed [17:0] rdx_q, rdy_q;
	logic [23:0] dx_q, dy_q;
	logic [32:0] sdx_q, sdy_q;
	logic signed [10:0] mx_q, my_q;
	logic side_q, inb_q;
	logic [7:0] steps_q, kind_q;
	logic [15:0] dist_q;
	logic [rcast_pkg::NUM_W-1:0] h_q;
	logic signed [34:0] wprod_q;
	rcast_pkg::result_t res_q, out_q;
	logic out_valid_q;
	rcast_pkg::div_req_t div_req_q;
	logic [rcast_pkg::NUM_W-1:0] div_quo;
	logic div_done;
	logic div_go;
	logic [15:0] col_depth [NUM_COLS];

	logic map_busy;
	logic map_we;
	logic [AW-1:0] map_waddr, map_raddr;
	logic [7:0] map_rdata;

	logic in_fire;
	logic out_free;
	logic [36:0] camx_mul;
	logic [31:0] camx_prod_x, camx_prod_y;
	logic [16:0] abs_rdx, abs_rdy;
	logic [8:0] fac_x, fac_y;
	logic [32:0] sdx_prod, sdy_prod;
	logic step_x;
	logic signed [10:0] mx_n, my_n;
	logic [32:0] sdx_n, sdy_n;
	logic inb_n;
	logic [15:0] raddr_full, waddr_full;
	logic [7:0] kind_n;
	logic [32:0] dist_raw;
	logic [15:0] dist_n;
	logic signed [22:0] h_s, ws_raw, we_raw;
	logic signed [15:0] ws_n, we_n;
	logic [7:0] wall_lo;
	logic [16:0] tex_prod;
	logic [CW-1:0] col_idx;

	rcast_map #(.AW(AW), .DEPTH(MAP_DIM * MAP_DIM)) u_map (
		.clk(clk), .arst_n(arst_n), .wr_en(map_we), .wr_addr(map_waddr), .wr_data(req.cell_value),
		.rd_addr(map_raddr), .rd_data(map_rdata), .busy(map_busy)
	);

	rcast_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req_q), .quo(div_quo), .done(div_done));

	assign req.ready = (state_q == S_IDLE) && !map_busy;
	assign in_fire = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;

	// map write port
	assign waddr_full = 16'({8'd0, 2'd0, req.cell_y} * 16'(MAP_DIM)) + {10'd0, req.cell_x};
	assign map_waddr = AW'(waddr_full);
	assign map_we = in_fire && (req.op == rcast_pkg::OP_WRITE) && ({3'd0, req.cell_x} < 9'(MAP_DIM))
		&& ({3'd0, req.cell_y} < 9'(MAP_DIM));

	// ray direction and deltas
	assign camx_mul = 37'(col_q * CAMX_RECIP);
	assign camx_prod_x = 32'($signed(plane_x_q) * camx_q);
	assign camx_prod_y = 32'($signed(plane_y_q) * camx_q);
	assign abs_rdx = rdx_q[17] ? 17'(-rdx_q) : 17'(rdx_q);
	assign abs_rdy = rdy_q[17] ? 17'(-rdy_q) : 17'(rdy_q);
	assign fac_x = rdx_q[17] ? {1'b0, pos_x_q[7:0]} : 9'd256 - {1'b0, pos_x_q[7:0]};
	assign fac_y = rdy_q[17] ? {1'b0, pos_y_q[7:0]} : 9'd256 - {1'b0, pos_y_q[7:0]};
	assign sdx_prod = 33'(fac_x * dx_q);
	assign sdy_prod = 33'(fac_y * dy_q);

	// one dda step, ties go to y
	always_comb begin
		step_x = sdx_q < sdy_q;
		mx_n = mx_q;
		my_n = my_q;
		sdx_n = sdx_q;
		sdy_n = sdy_q;
		if (step_x) begin
			sdx_n = sdx_q + {9'd0, dx_q};
			mx_n = rdx_q[17] ? mx_q - 11'sd1 : mx_q + 11'sd1;
		end else begin
			sdy_n = sdy_q + {9'd0, dy_q};
			my_n = rdy_q[17] ? my_q - 11'sd1 : my_q + 11'sd1;
		end
	end

	assign inb_n = !mx_n[10] && !my_n[10] && ($unsigned(mx_n) < 11'(MAP_DIM))
		&& ($unsigned(my_n) < 11'(MAP_DIM));
	assign raddr_full = 16'({8'd0, my_n[7:0]} * 16'(MAP_DIM)) + {8'd0, mx_n[7:0]};
	assign map_raddr = AW'(raddr_full);
	assign kind_n = inb_q ? map_rdata : 8'd0;

	assign dist_raw = side_q ? sdy_q - {9'd0, dy_q} : sdx_q - {9'd0, dx_q};
	assign dist_n = (dist_raw > 33'hFFFF) ? 16'hFFFF : dist_raw[15:0];

	// wall slice rows and texture column
	assign h_s = $signed({1'b0, h_q[21:0]});
	assign ws_raw = (23'(NUM_ROWS) - h_s) >>> 1;
	assign we_raw = (23'(NUM_ROWS) + h_s) >>> 1;
	assign ws_n = (ws_raw > 23'sd32767) ? 16'sd32767 : (ws_raw < -23'sd32768) ? -16'sd32768
		: ws_raw[15:0];
	assign we_n = (we_raw > 23'sd32767) ? 16'sd32767 : (we_raw < -23'sd32768) ? -16'sd32768
		: we_raw[15:0];
	assign wall_lo = (side_q ? pos_x_q[7:0] : pos_y_q[7:0]) + wprod_q[21:14];
	assign tex_prod = 17'({9'd0, wall_lo} * 17'(TEXTURE_SIZE));
	assign col_idx = CW'(col_q);

	assign div_go = (state_q == S_RDY) || ((state_q == S_DX) && div_done) || (state_q == S_DIST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= 16'd0;
			pos_y_q <= 16'd0;
			dir_x_q <= 16'd16384;
			dir_y_q <= 16'd0;
			plane_x_q <= 16'd0;
			plane_y_q <= 16'd10813;
		end else if (wr_en) begin
			case (wr_index)
				rcast_pkg::REG_POS_X: pos_x_q <= wr_data;
				rcast_pkg::REG_POS_Y: pos_y_q <= wr_data;
				rcast_pkg::REG_DIR_X: dir_x_q <= wr_data;
				rcast_pkg::REG_DIR_Y: dir_y_q <= wr_data;
				rcast_pkg::REG_PLANE_X: plane_x_q <= wr_data;
				rcast_pkg::REG_PLANE_Y: plane_y_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			div_req_q <= '0;
		end else begin
			div_req_q.start <= div_go;
			if (state_q == S_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_fire && req.op == rcast_pkg::OP_CAST
						&& ({3'd0, req.column} < 13'(NUM_COLS)))
						state_q <= S_CAM;
				end
				S_CAM: state_q <= S_RDX;
				S_RDX: state_q <= S_RDY;
				S_RDY: begin
					div_req_q.num <= rcast_pkg::NUM_W'(1) << 22;
					div_req_q.den <= (abs_rdx == '0) ? rcast_pkg::DEN_W'(1) : abs_rdx;
					state_q <= S_DX;
				end
				S_DX: begin
					if (div_done) begin
						div_req_q.num <= rcast_pkg::NUM_W'(1) << 22;
						div_req_q.den <= (abs_rdy == '0) ? rcast_pkg::DEN_W'(1) : abs_rdy;
						state_q <= S_DY;
					end
				end
				S_DY: if (div_done) state_q <= S_SDX;
				S_SDX: state_q <= S_SDY;
				S_SDY: state_q <= S_STEP;
				S_STEP: state_q <= S_CHK;
				S_CHK: begin
					if (kind_n != 8'd0)
						state_q <= S_DIST;
					else if (steps_q == 8'(MAX_STEPS - 1))
						state_q <= S_DONE;
					else
						state_q <= S_STEP;
				end
				S_DIST: begin
					div_req_q.num <= rcast_pkg::NUM_W'(NUM_ROWS) << 8;
					div_req_q.den <= (dist_n == 16'd0) ? rcast_pkg::DEN_W'(1) : {1'b0, dist_n};
					state_q <= S_HDIV;
				end
				S_HDIV: if (div_done) state_q <= S_WALL;
				S_WALL: state_q <= S_FIN;
				S_FIN: state_q <= S_DONE;
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: col_q <= req.column;
			S_CAM: camx_q <= $signed({1'b0, camx_mul[36:22]} - rcast_pkg::CAMX_BIAS);
			S_RDX: rdx_q <= {{2{dir_x_q[15]}}, dir_x_q} + camx_prod_x[31:14];
			S_RDY: rdy_q <= {{2{dir_y_q[15]}}, dir_y_q} + camx_prod_y[31:14];
			S_DX: if (div_done) dx_q <= (abs_rdx == '0) ? rcast_pkg::DELTA_SAT : div_quo[23:0];
			S_DY: if (div_done) dy_q <= (abs_rdy == '0) ? rcast_pkg::DELTA_SAT : div_quo[23:0];
			S_SDX: begin
				sdx_q <= {8'd0, sdx_prod[32:8]};
				mx_q <= $signed({3'd0, pos_x_q[15:8]});
			end
			S_SDY: begin
				sdy_q <= {8'd0, sdy_prod[32:8]};
				my_q <= $signed({3'd0, pos_y_q[15:8]});
				steps_q <= 8'd0;
			end
			S_STEP: begin
				sdx_q <= sdx_n;
				sdy_q <= sdy_n;
				mx_q <= mx_n;
				my_q <= my_n;
				side_q <= !step_x;
				inb_q <= inb_n;
			end
			S_CHK: begin
				steps_q <= steps_q + 8'd1;
				kind_q <= kind_n;
				// a miss leaves every field but the column at zero
				res_q <= {col_q, {($bits(rcast_pkg::result_t) - 10){1'b0}}};
			end
			S_DIST: dist_q <= dist_n;
			S_HDIV: if (div_done) h_q <= div_quo;
			S_WALL: wprod_q <= $signed({1'b0, dist_q}) * (side_q ? rdx_q : rdy_q);
			S_FIN: begin
				res_q.hit <= 1'b1;
				res_q.wall_kind <= kind_q;
				res_q.side_y <= side_q;
				res_q.distance <= dist_q;
				res_q.wall_start <= (dist_q == 16'd0) ? -16'sd32768 : ws_n;
				res_q.wall_end <= (dist_q == 16'd0) ? 16'sd32767 : we_n;
				res_q.tex_x <= tex_prod[13:8];
				res_q.door_found <= (kind_q == rcast_pkg::DOOR_KIND)
					&& (dist_q <= rcast_pkg::DOOR_DIST);
				col_depth[col_idx] <= dist_q;
			end
			S_DONE: if (out_free) out_q <= res_q;
			default: ;
		endcase
	end

	assign rsp.valid = out_valid_q;
	assign rsp.column_out = out_q.column_out;
	assign rsp.hit = out_q.hit;
	assign rsp.wall_kind = out_q.wall_kind;
	assign rsp.side_y = out_q.side_y;
	assign rsp.distance = out_q.distance;
	assign rsp.wall_start = out_q.wall_start;
	assign rsp.wall_end = out_q.wall_end;
	assign rsp.tex_x = out_q.tex_x;
	assign rsp.door_found = out_q.door_found;

endmodule

// ===== tb/dda_wall_column_cast_tb.sv =====
// testbench for the grid column ray caster: directed table then random casts, scoreboard check
`timescale 1ns / 100ps

module dda_wall_column_cast_tb;

	localparam int SCR_W = 1024;
	localparam int SCR_H = 768;
	localparam int GRID = 64;
	localparam int STEP_LIMIT = 60;
	localparam int TEX_SIZE = 64;
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 400;
	localparam logic [2:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic op;
		logic [9:0] column;
		logic [5:0] cell_x;
		logic [5:0] cell_y;
		logic [7:0] cell_value;
	} cast_req_t;

	typedef struct {
		cast_req_t req;
		logic known;
		rcast_pkg::result_t res;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [2:0] wr_index;
	logic [15:0] wr_data;

	rcast_in_if req_ch();
	rcast_out_if rsp_ch();

	dda_wall_column_cast u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	logic [15:0] view_pos_x, view_pos_y;
	logic signed [15:0] view_dir_x, view_dir_y, view_plane_x, view_plane_y;
	logic [7:0] grid_cells [GRID*GRID];
	rcast_pkg::result_t pending_columns [$];
	int mismatch_count;
	int idle_cycles;
	int send_idle_pct;
	int recv_stall_pct;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint floor_div_pow2(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint ray_delta(longint rd);
		longint mag;
		longint d;
		mag = rd < 0 ? -rd : rd;
		if (mag == 0)
			return longint'(rcast_pkg::DELTA_SAT);
		d = (longint'(1) << 22) / mag;
		return d > longint'(rcast_pkg::DELTA_SAT) ? longint'(rcast_pkg::DELTA_SAT) : d;
	endfunction

	function automatic logic [7:0] grid_read(longint x, longint y);
		if (x < 0 || y < 0 || x >= GRID || y >= GRID)
			return 8'd0;
		return grid_cells[y*GRID + x];
	endfunction

	function automatic rcast_pkg::result_t cast_column(logic [9:0] col);
		rcast_pkg::result_t r;
		longint camx, rdx, rdy, mx, my, stx, sty, dx, dy, sdx, sdy, perp, h, ws, we, wallx;
		logic [7:0] kind;
		logic side;
		r = '0;
		kind = 8'd0;
		side = 1'b0;
		camx = ((longint'(col) << 15) / SCR_W) - 16384;
		rdx = longint'(view_dir_x) + floor_div_pow2(longint'(view_plane_x) * camx, 14);
		rdy = longint'(view_dir_y) + floor_div_pow2(longint'(view_plane_y) * camx, 14);
		dx = ray_delta(rdx);
		dy = ray_delta(rdy);
		mx = view_pos_x >> 8;
		my = view_pos_y >> 8;
		if (rdx < 0) begin
			stx = -1;
			sdx = (longint'(view_pos_x[7:0]) * dx) >> 8;
		end else begin
			stx = 1;
			sdx = ((256 - longint'(view_pos_x[7:0])) * dx) >> 8;
		end
		if (rdy < 0) begin
			sty = -1;
			sdy = (longint'(view_pos_y[7:0]) * dy) >> 8;
		end else begin
			sty = 1;
			sdy = ((256 - longint'(view_pos_y[7:0])) * dy) >> 8;
		end
		for (int s = 0; kind == 0 && s < STEP_LIMIT; s++) begin
			if (sdx < sdy) begin
				sdx += dx;
				mx += stx;
				side = 1'b0;
			end else begin
				sdy += dy;
				my += sty;
				side = 1'b1;
			end
			kind = grid_read(mx, my);
		end
		r.column_out = col;
		if (kind == 0)
			return r;
		perp = side ? sdy - dy : sdx - dx;
		if (perp > 65535)
			perp = 65535;
		if (perp == 0) begin
			ws = -32768;
			we = 32767;
		end else begin
			h = (longint'(SCR_H) << 8) / perp;
			ws = floor_div_pow2(SCR_H - h, 1);
			we = floor_div_pow2(SCR_H + h, 1);
			ws = ws < -32768 ? -32768 : (ws > 32767 ? 32767 : ws);
			we = we < -32768 ? -32768 : (we > 32767 ? 32767 : we);
		end
		if (side)
			wallx = longint'(view_pos_x) + floor_div_pow2(perp * rdx, 14);
		else
			wallx = longint'(view_pos_y) + floor_div_pow2(perp * rdy, 14);
		r.hit = 1'b1;
		r.wall_kind = kind;
		r.side_y = side;
		r.distance = perp[15:0];
		r.wall_start = ws[15:0];
		r.wall_end = we[15:0];
		r.tex_x = 6'(((wallx & 255) * TEX_SIZE) >> 8);
		r.door_found = (kind == rcast_pkg::DOOR_KIND) && (perp <= longint'(rcast_pkg::DOOR_DIST));
		return r;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		case (idx)
			rcast_pkg::REG_POS_X: view_pos_x = val;
			rcast_pkg::REG_POS_Y: view_pos_y = val;
			rcast_pkg::REG_DIR_X: view_dir_x = val;
			rcast_pkg::REG_DIR_Y: view_dir_y = val;
			rcast_pkg::REG_PLANE_X: view_plane_x = val;
			rcast_pkg::REG_PLANE_Y: view_plane_y = val;
			default: ;
		endcase
	endtask

	task automatic set_view(logic [15:0] px, logic [15:0] py, logic [15:0] dxv,
		logic [15:0] dyv, logic [15:0] plx, logic [15:0] ply);
		req_ch.valid <= 1'b0;
		// let every pending cast deliver its result and the caster settle before touching registers
		while (pending_columns.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(rcast_pkg::REG_POS_X, px);
		write_reg(rcast_pkg::REG_POS_Y, py);
		write_reg(rcast_pkg::REG_DIR_X, dxv);
		write_reg(rcast_pkg::REG_DIR_Y, dyv);
		write_reg(rcast_pkg::REG_PLANE_X, plx);
		write_reg(rcast_pkg::REG_PLANE_Y, ply);
		write_reg(REG_UNUSED, 16'($urandom));
		wr_en <= 1'b0;
	endtask

	// drive one transaction; predicts at acceptance
	task automatic send_item(cast_req_t it, logic known, rcast_pkg::result_t typed);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= it.op;
		req_ch.column <= it.column;
		req_ch.cell_x <= it.cell_x;
		req_ch.cell_y <= it.cell_y;
		req_ch.cell_value <= it.cell_value;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		if (it.op == rcast_pkg::OP_WRITE) begin
			grid_cells[{it.cell_y, it.cell_x}] = it.cell_value;
		end else if (it.column < SCR_W) begin
			if (known)
				pending_columns.push_back(typed);
			else
				pending_columns.push_back(cast_column(it.column));
		end
	endtask

	function automatic cast_req_t cast_of(logic [9:0] col);
		cast_req_t it;
		it = '0;
		it.op = rcast_pkg::OP_CAST;
		it.column = col;
		return it;
	endfunction

	function automatic cast_req_t cell_write(logic [5:0] x, logic [5:0] y, logic [7:0] v);
		cast_req_t it;
		it.op = rcast_pkg::OP_WRITE;
		it.column = 10'($urandom);
		it.cell_x = x;
		it.cell_y = y;
		it.cell_value = v;
		return it;
	endfunction

	always @(posedge clk) begin
		rcast_pkg::result_t got, want;
		if (arst_n) begin
			rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = '{rsp_ch.column_out, rsp_ch.hit, rsp_ch.wall_kind, rsp_ch.side_y,
					rsp_ch.distance, rsp_ch.wall_start, rsp_ch.wall_end, rsp_ch.tex_x,
					rsp_ch.door_found};
				if (pending_columns.size() == 0) begin
					$error("result for column %0d with nothing expected", got.column_out);
					mismatch_count++;
				end else begin
					want = pending_columns.pop_front();
					if (got.column_out !== want.column_out) begin
						$error("column_out exp %0d got %0d", want.column_out, got.column_out);
						mismatch_count++;
					end
					if (got.hit !== want.hit) begin
						$error("hit exp %0d got %0d", want.hit, got.hit);
						mismatch_count++;
					end
					if (got.wall_kind !== want.wall_kind) begin
						$error("wall_kind exp %0d got %0d", want.wall_kind, got.wall_kind);
						mismatch_count++;
					end
					if (got.side_y !== want.side_y) begin
						$error("side_y exp %0d got %0d", want.side_y, got.side_y);
						mismatch_count++;
					end
					if (got.distance !== want.distance) begin
						$error("distance exp %0d got %0d", want.distance, got.distance);
						mismatch_count++;
					end
					if (got.wall_start !== want.wall_start) begin
						$error("wall_start exp %0d got %0d", want.wall_start, got.wall_start);
						mismatch_count++;
					end
					if (got.wall_end !== want.wall_end) begin
						$error("wall_end exp %0d got %0d", want.wall_end, got.wall_end);
						mismatch_count++;
					end
					if (got.tex_x !== want.tex_x) begin
						$error("tex_x exp %0d got %0d", want.tex_x, got.tex_x);
						mismatch_count++;
					end
					if (got.door_found !== want.door_found) begin
						$error("door_found exp %0d got %0d", want.door_found, got.door_found);
						mismatch_count++;
					end
				end
			end
		end
	end

	// watchdog; covers the map clear after reset and the slowest cast under stall
	always @(posedge clk) begin
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	stim_row_t directed [$];

	task automatic add_row(cast_req_t it, logic known, rcast_pkg::result_t r);
		stim_row_t row;
		row.req = it;
		row.known = known;
		row.res = r;
		directed.push_back(row);
	endtask

	function automatic rcast_pkg::result_t miss_of(logic [9:0] col);
		rcast_pkg::result_t r;
		r = '0;
		r.column_out = col;
		return r;
	endfunction

	task automatic random_phase(int n, int sidle, int rstall);
		int wx, wy;
		send_idle_pct = sidle;
		recv_stall_pct = rstall;
		// room with random walls; viewer inside
		set_view({8'($urandom_range(1, 14)), 8'($urandom)}, {8'($urandom_range(1, 14)), 8'($urandom)},
			$urandom_range(0, 1) ? 16'($signed($urandom_range(0, 32767)) - 16384) : 16'($urandom),
			$urandom_range(0, 1) ? 16'($signed($urandom_range(0, 32767)) - 16384) : 16'($urandom),
			16'($urandom), 16'($urandom));
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 30) begin
				wx = $urandom_range(99) < 80 ? $urandom_range(0, 16) : $urandom_range(0, 63);
				wy = $urandom_range(99) < 80 ? $urandom_range(0, 16) : $urandom_range(0, 63);
				send_item(cell_write(6'(wx), 6'(wy),
					$urandom_range(99) < 20 ? rcast_pkg::DOOR_KIND : 8'($urandom)), 1'b0, '0);
			end else begin
				send_item(cast_of(10'($urandom_range(99) < 95 ? $urandom_range(0, SCR_W - 1) :
					$urandom)), 1'b0, '0);
			end
		end
	endtask

	initial begin
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		req_ch.valid = 1'b0;
		req_ch.op = rcast_pkg::OP_WRITE;
		req_ch.column = '0;
		req_ch.cell_x = '0;
		req_ch.cell_y = '0;
		req_ch.cell_value = '0;
		rsp_ch.ready = 1'b0;
		mismatch_count = 0;
		idle_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		view_pos_x = 0;
		view_pos_y = 0;
		view_dir_x = 16384;
		view_dir_y = 0;
		view_plane_x = 0;
		view_plane_y = 10813;
		foreach (grid_cells[i])
			grid_cells[i] = 8'd0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// empty map after reset: every cast misses
		add_row(cast_of(10'd0), 1'b1, miss_of(10'd0));
		add_row(cast_of(10'd1023), 1'b1, miss_of(10'd1023));
		add_row(cast_of(10'd512), 1'b1, miss_of(10'd512));
		// a column past the screen gives nothing, but with SCR_W at 1024 every 10-bit column is valid here
		add_row(cell_write(6'd1, 6'd0, 8'd7), 1'b0, '0);
		add_row(cell_write(6'd63, 6'd63, 8'd255), 1'b0, '0);
		add_row(cell_write(6'd0, 6'd1, rcast_pkg::DOOR_KIND), 1'b0, '0);
		add_row(cell_write(6'd2, 6'd0, 8'd1), 1'b0, '0);
		add_row(cast_of(10'd512), 1'b0, '0);
		add_row(cast_of(10'd0), 1'b0, '0);
		add_row(cast_of(10'd1023), 1'b0, '0);
		add_row(cast_of(10'd256), 1'b0, '0);
		add_row(cast_of(10'd768), 1'b0, '0);
		add_row(cell_write(6'd0, 6'd0, 8'd0), 1'b0, '0);
		add_row(cell_write(6'd1, 6'd0, 8'd0), 1'b0, '0);
		foreach (directed[i])
			send_item(directed[i].req, directed[i].known, directed[i].res);
		directed.delete();

		// viewer right next to a door, zero ray component
		set_view(16'h0080, 16'h0080, 16'h0000, 16'h4000, 16'h0000, 16'h0000);
		add_row(cast_of(10'd100), 1'b0, '0);
		set_view(16'h00FF, 16'h0080, 16'h4000, 16'h0000, 16'h0000, 16'h0000);
		add_row(cast_of(10'd0), 1'b0, '0);
		foreach (directed[i])
			send_item(directed[i].req, directed[i].known, directed[i].res);
		// negative extremes pointing off the grid: cells outside read empty
		set_view(16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000);
		send_item(cast_of(10'd0), 1'b0, '0);
		send_item(cast_of(10'd1023), 1'b0, '0);
		set_view(16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF);
		send_item(cast_of(10'd511), 1'b0, '0);

		// seed a box of walls around the low corner
		for (int k = 0; k < 16; k++) begin
			send_item(cell_write(6'(k), 6'd0, 8'($urandom_range(1, 255))), 1'b0, '0);
			send_item(cell_write(6'(k), 6'd15, 8'($urandom_range(1, 255))), 1'b0, '0);
			send_item(cell_write(6'd0, 6'(k), rcast_pkg::DOOR_KIND), 1'b0, '0);
			send_item(cell_write(6'd15, 6'(k), 8'($urandom_range(1, 255))), 1'b0, '0);
		end

		random_phase(115, 0, 0);
		random_phase(115, 50, 0);
		random_phase(115, 0, 50);
		random_phase(115, 12, 12);

		req_ch.valid <= 1'b0;
		while (pending_columns.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_columns.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
